FILE: rtl/vtp_pkg.sv
// Package for the VT escape sequence parser: parser state codes, result kinds,
// character constants, default sizes and small character-class helpers.
// Used by the top level vt_escape_sequence_parser; depends on nothing.
package vtp_pkg;

    localparam int MAX_PARAMS_DEF = 16;
    localparam int OSC_DEPTH_DEF  = 63;

    localparam int CP_W    = 21;
    localparam int PVAL_W  = 20;
    localparam int ENTRY_W = 22;

    localparam logic [PVAL_W-1:0] VAL_CLAMP = 20'd100000;

    // Parser states.
    localparam logic [3:0] ST_GROUND    = 4'd0;
    localparam logic [3:0] ST_ESC       = 4'd1;
    localparam logic [3:0] ST_ESC_INTER = 4'd2;
    localparam logic [3:0] ST_CSI_ENTRY = 4'd3;
    localparam logic [3:0] ST_CSI_PARAM = 4'd4;
    localparam logic [3:0] ST_CSI_INTER = 4'd5;
    localparam logic [3:0] ST_CSI_IGN   = 4'd6;
    localparam logic [3:0] ST_OSC       = 4'd7;
    localparam logic [3:0] ST_STR_IGN   = 4'd8;

    // Dispatch sequencer states.
    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_READ = 2'd1;
    localparam logic [1:0] SQ_EMIT = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_PRINT = 3'd0;
    localparam logic [2:0] KIND_CTRL  = 3'd1;
    localparam logic [2:0] KIND_ESC   = 3'd2;
    localparam logic [2:0] KIND_CSI   = 3'd3;
    localparam logic [2:0] KIND_OSC   = 3'd4;

    // Characters.
    localparam logic [CP_W-1:0] CH_BEL   = 21'h07;
    localparam logic [CP_W-1:0] CH_CAN   = 21'h18;
    localparam logic [CP_W-1:0] CH_SUB   = 21'h1A;
    localparam logic [CP_W-1:0] CH_ESC   = 21'h1B;
    localparam logic [CP_W-1:0] CH_SPACE = 21'h20;
    localparam logic [CP_W-1:0] CH_DEL   = 21'h7F;
    localparam logic [CP_W-1:0] CH_COLON = 21'h3A;
    localparam logic [CP_W-1:0] CH_SEMI  = 21'h3B;
    localparam logic [CP_W-1:0] CH_LBRK  = 21'h5B;
    localparam logic [CP_W-1:0] CH_BSLS  = 21'h5C;
    localparam logic [CP_W-1:0] CH_RBRK  = 21'h5D;
    localparam logic [CP_W-1:0] CH_DCS   = 21'h50;
    localparam logic [CP_W-1:0] CH_SOS   = 21'h58;
    localparam logic [CP_W-1:0] CH_PM    = 21'h5E;
    localparam logic [CP_W-1:0] CH_APC   = 21'h5F;

    function automatic logic is_inter(input logic [CP_W-1:0] c);
        return (c >= 21'h20) && (c <= 21'h2F);
    endfunction

    function automatic logic is_final(input logic [CP_W-1:0] c);
        return (c >= 21'h40) && (c <= 21'h7E);
    endfunction

    function automatic logic is_marker(input logic [CP_W-1:0] c);
        return c inside {21'h3C, 21'h3D, 21'h3E, 21'h3F};
    endfunction

    function automatic logic is_digit(input logic [CP_W-1:0] c);
        return (c >= 21'h30) && (c <= 21'h39);
    endfunction

    // Value times ten plus a decimal digit, by shifts and adds.
    function automatic logic [PVAL_W-1:0] mul10_add(input logic [PVAL_W-1:0] v,
                                                    input logic [CP_W-1:0] c);
        logic [3:0] d;
        d = c[3:0];
        return (v << 3) + (v << 1) + {16'd0, d};
    endfunction

endpackage

FILE: rtl/vt_escape_sequence_parser.sv
// Top level of the VT escape sequence parser: state machine, stores and
// dispatch sequencer. Depends on vtp_pkg and vtp_ram.
//
// Usage. One code point is transferred on the input channel (cp_valid,
// cp_stall, code_point) and zero or more results leave on the result channel
// (res_valid, res_stall and the result fields). Prints, controls, escape
// dispatches, a CSI dispatch with no parameters and an OSC dispatch with an
// empty payload are written to the result register in the cycle the code
// point is taken, so they appear in the next cycle. A CSI dispatch streams
// one result per parameter from the parameter RAM (the open parameter from
// its registers), and an OSC dispatch one result per payload character from
// the OSC RAM. Each streamed result passes a RAM read state and then a state
// that loads the result register, and no code point is taken during a
// dispatch. The open parameter is kept in registers and written to the RAM
// only when a separator closes it, so each code point costs at most one RAM
// write. The OSC command number is parsed while the string is stored.
// When the receiver stalls the result stays in the result register and the
// input stalls too. Reset empties the result register and returns the parser
// to ground with no sequence held; the RAMs need no clearing, since only
// entries written since the sequence began are ever read.
module vt_escape_sequence_parser #(
    parameter int MAX_PARAMS = vtp_pkg::MAX_PARAMS_DEF,
    parameter int OSC_DEPTH  = vtp_pkg::OSC_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cp_valid,
    output logic               cp_stall,
    input  logic [20:0]        code_point,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [2:0]         kind,
    output logic [20:0]        char_value,
    output logic [6:0]         inter_byte,
    output logic [6:0]         marker_byte,
    output logic signed [20:0] number,
    output logic               param_omitted,
    output logic               param_sub,
    output logic               item_valid,
    output logic               last
);

    localparam int PAW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int OAW = (OSC_DEPTH > 1) ? $clog2(OSC_DEPTH) : 1;
    localparam int CW  = $clog2(MAX_PARAMS + 1);
    localparam int OLW = $clog2(OSC_DEPTH + 1);
    localparam int IW  = (CW > OLW) ? CW : OLW;
    localparam logic [CW-1:0]  CNT_MAX = CW'(MAX_PARAMS);
    localparam logic [OLW-1:0] OSC_MAX = OLW'(OSC_DEPTH);

    // Parser state.
    logic [3:0]  state_reg, state_next;
    logic        pend_reg, pend_next;
    logic        open_reg, open_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [6:0]  mark_reg, mark_next;
    logic [6:0]  inter_reg, inter_next;
    // Open parameter, held in registers until a separator closes it.
    logic [19:0] oval_reg, oval_next;
    logic        osub_reg, osub_next;
    logic        oomit_reg, oomit_next;
    // OSC length and the command parse that runs while storing.
    logic [OLW-1:0] olen_reg, olen_next;
    logic        sepf_reg, sepf_next;
    logic [OLW-1:0] sepi_reg, sepi_next;
    logic        numok_reg, numok_next;
    logic [19:0] cval_reg, cval_next;
    // Dispatch sequencer.
    logic [1:0]  seq_reg, seq_next;
    logic        mode_osc_reg, mode_osc_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] end_reg, end_next;
    logic [20:0] fin_reg, fin_next;
    logic [20:0] cmd_reg, cmd_next;
    // Result register.
    logic        rv_reg, rv_next;
    logic [2:0]  kind_reg, kind_next;
    logic [20:0] cv_reg, cv_next;
    logic [6:0]  ib_reg, ib_next;
    logic [6:0]  mb_reg, mb_next;
    logic [20:0] num_reg, num_next;
    logic        om_reg, om_next;
    logic        sub_reg, sub_next;
    logic        iv_reg, iv_next;
    logic        last_reg, last_next;

    // RAM ports.
    logic                pw_en, ow_en, rd_en;
    logic [PAW-1:0]      pw_addr;
    logic [OAW-1:0]      ow_addr;
    logic [21:0]         pw_data;
    logic [20:0]         ow_data;
    logic [21:0]         p_rdata;
    logic [20:0]         o_rdata;

    logic accept;
    logic out_free;

    assign out_free = !rv_reg || !res_stall;
    assign cp_stall = (seq_reg != vtp_pkg::SQ_IDLE) || !out_free;
    assign accept   = cp_valid && !cp_stall;

    vtp_ram #(.WIDTH(vtp_pkg::ENTRY_W), .DEPTH(MAX_PARAMS)) u_param_ram (
        .clk   (clk),
        .we    (pw_en),
        .waddr (pw_addr),
        .wdata (pw_data),
        .re    (rd_en && !mode_osc_reg),
        .raddr (idx_reg[PAW-1:0]),
        .rdata (p_rdata)
    );

    vtp_ram #(.WIDTH(vtp_pkg::CP_W), .DEPTH(OSC_DEPTH)) u_osc_ram (
        .clk   (clk),
        .we    (ow_en),
        .waddr (ow_addr),
        .wdata (ow_data),
        .re    (rd_en && mode_osc_reg),
        .raddr (idx_reg[OAW-1:0]),
        .rdata (o_rdata)
    );

    always_comb
    begin
        logic [20:0]   c;
        logic [3:0]    s_eff;
        logic          done;
        logic          clr;
        logic          ld;
        logic [19:0]   v;
        logic [CW-1:0] cw;
        logic [CW-1:0] cm1;
        logic [OLW-1:0] sep;
        logic [OLW-1:0] start;
        logic          numeric;
        logic          osc_end;
        logic          csi_disp;
        logic [IW-1:0] idx_inc;
        logic          use_open;
        logic [21:0]   e;

        c        = code_point;
        s_eff    = state_reg;
        done     = 1'b0;
        clr      = 1'b0;
        ld       = 1'b0;
        v        = '0;
        cw       = cnt_reg;
        cm1      = cnt_reg - CW'(1);
        sep      = '0;
        start    = '0;
        numeric  = 1'b0;
        osc_end  = 1'b0;
        csi_disp = 1'b0;
        idx_inc  = idx_reg + IW'(1);
        use_open = 1'b0;
        e        = '0;

        state_next    = state_reg;
        pend_next     = pend_reg;
        open_next     = open_reg;
        cnt_next      = cnt_reg;
        mark_next     = mark_reg;
        inter_next    = inter_reg;
        oval_next     = oval_reg;
        osub_next     = osub_reg;
        oomit_next    = oomit_reg;
        olen_next     = olen_reg;
        sepf_next     = sepf_reg;
        sepi_next     = sepi_reg;
        numok_next    = numok_reg;
        cval_next     = cval_reg;
        seq_next      = seq_reg;
        mode_osc_next = mode_osc_reg;
        idx_next      = idx_reg;
        end_next      = end_reg;
        fin_next      = fin_reg;
        cmd_next      = cmd_reg;

        kind_next = kind_reg;
        cv_next   = cv_reg;
        ib_next   = ib_reg;
        mb_next   = mb_reg;
        num_next  = num_reg;
        om_next   = om_reg;
        sub_next  = sub_reg;
        iv_next   = iv_reg;
        last_next = last_reg;

        pw_en   = 1'b0;
        pw_addr = '0;
        pw_data = '0;
        ow_en   = 1'b0;
        ow_addr = olen_reg[OAW-1:0];
        ow_data = c;
        rd_en   = 1'b0;

        if (seq_reg == vtp_pkg::SQ_READ)
        begin
            rd_en    = 1'b1;
            seq_next = vtp_pkg::SQ_EMIT;
        end
        else if (seq_reg == vtp_pkg::SQ_EMIT)
        begin
            if (out_free)
            begin
                ld        = 1'b1;
                iv_next   = 1'b1;
                ib_next   = '0;
                mb_next   = '0;
                om_next   = 1'b0;
                sub_next  = 1'b0;
                last_next = (idx_inc == end_reg);
                if (mode_osc_reg)
                begin
                    kind_next = vtp_pkg::KIND_OSC;
                    cv_next   = o_rdata;
                    num_next  = cmd_reg;
                end
                else
                begin
                    use_open  = open_reg && (idx_reg == IW'(cm1));
                    e         = use_open ? {osub_reg, oomit_reg, oval_reg} : p_rdata;
                    kind_next = vtp_pkg::KIND_CSI;
                    cv_next   = fin_reg;
                    ib_next   = inter_reg;
                    mb_next   = mark_reg;
                    om_next   = e[20];
                    sub_next  = e[21];
                    num_next  = e[20] ? '1 : {1'b0, e[19:0]};
                end
                idx_next = idx_inc;
                if (idx_inc == end_reg)
                begin
                    seq_next = vtp_pkg::SQ_IDLE;
                    if (mode_osc_reg)
                    begin
                        olen_next = '0;
                    end
                    else
                    begin
                        clr = 1'b1;
                    end
                end
                else
                begin
                    seq_next = vtp_pkg::SQ_READ;
                end
            end
        end
        else if (accept)
        begin
            // String states first; an ESC followed by anything but a backslash
            // drops the string and falls through to escape handling.
            if (state_reg == vtp_pkg::ST_OSC || state_reg == vtp_pkg::ST_STR_IGN)
            begin
                done = 1'b1;
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (c == vtp_pkg::CH_BSLS)
                    begin
                        osc_end    = (state_reg == vtp_pkg::ST_OSC);
                        state_next = vtp_pkg::ST_GROUND;
                        olen_next  = '0;
                    end
                    else
                    begin
                        // The sequence is cleared here so that the escape
                        // handling below can still record an intermediate.
                        olen_next  = '0;
                        cnt_next   = '0;
                        mark_next  = '0;
                        inter_next = '0;
                        open_next  = 1'b0;
                        s_eff      = vtp_pkg::ST_ESC;
                        done       = 1'b0;
                    end
                end
                else if (c == vtp_pkg::CH_ESC)
                begin
                    pend_next = 1'b1;
                end
                else if (c == vtp_pkg::CH_BEL)
                begin
                    osc_end    = (state_reg == vtp_pkg::ST_OSC);
                    state_next = vtp_pkg::ST_GROUND;
                    olen_next  = '0;
                end
                else if (c == vtp_pkg::CH_CAN || c == vtp_pkg::CH_SUB)
                begin
                    state_next = vtp_pkg::ST_GROUND;
                    olen_next  = '0;
                end
                else if (state_reg == vtp_pkg::ST_OSC && olen_reg < OSC_MAX)
                begin
                    ow_en     = 1'b1;
                    olen_next = olen_reg + OLW'(1);
                    if (!sepf_reg)
                    begin
                        if (c == vtp_pkg::CH_SEMI)
                        begin
                            sepf_next = 1'b1;
                            sepi_next = olen_reg;
                        end
                        else if (vtp_pkg::is_digit(c) && numok_reg)
                        begin
                            v         = vtp_pkg::mul10_add(cval_reg, c);
                            cval_next = v;
                            if (v > vtp_pkg::VAL_CLAMP)
                            begin
                                numok_next = 1'b0;
                            end
                        end
                        else
                        begin
                            numok_next = 1'b0;
                        end
                    end
                end
            end

            if (osc_end)
            begin
                sep     = sepf_reg ? sepi_reg : olen_reg;
                numeric = (sep != '0) && numok_reg;
                start   = numeric ? (sepf_reg ? sepi_reg + OLW'(1) : olen_reg) : '0;
                cmd_next = numeric ? {1'b0, cval_reg} : '1;
                if (start >= olen_reg)
                begin
                    ld        = 1'b1;
                    kind_next = vtp_pkg::KIND_OSC;
                    cv_next   = '0;
                    ib_next   = '0;
                    mb_next   = '0;
                    num_next  = numeric ? {1'b0, cval_reg} : '1;
                    om_next   = 1'b0;
                    sub_next  = 1'b0;
                    iv_next   = 1'b0;
                    last_next = 1'b1;
                end
                else
                begin
                    // Keep the length until the stream ends.
                    olen_next     = olen_reg;
                    seq_next      = vtp_pkg::SQ_READ;
                    mode_osc_next = 1'b1;
                    idx_next      = IW'(start);
                    end_next      = IW'(olen_reg);
                end
            end

            if (!done)
            begin
                if (c < vtp_pkg::CH_SPACE)
                begin
                    if (c == vtp_pkg::CH_ESC)
                    begin
                        clr        = 1'b1;
                        state_next = vtp_pkg::ST_ESC;
                    end
                    else if (c == vtp_pkg::CH_CAN || c == vtp_pkg::CH_SUB)
                    begin
                        clr        = 1'b1;
                        state_next = vtp_pkg::ST_GROUND;
                    end
                    else
                    begin
                        ld        = 1'b1;
                        kind_next = vtp_pkg::KIND_CTRL;
                        cv_next   = c;
                        ib_next   = '0;
                        mb_next   = '0;
                        num_next  = '0;
                        om_next   = 1'b0;
                        sub_next  = 1'b0;
                        iv_next   = 1'b0;
                        last_next = 1'b1;
                        state_next = s_eff;
                    end
                end
                else
                begin
                    case (s_eff)
                        vtp_pkg::ST_GROUND:
                        begin
                            if (c != vtp_pkg::CH_DEL)
                            begin
                                ld        = 1'b1;
                                kind_next = vtp_pkg::KIND_PRINT;
                                cv_next   = c;
                                ib_next   = '0;
                                mb_next   = '0;
                                num_next  = '0;
                                om_next   = 1'b0;
                                sub_next  = 1'b0;
                                iv_next   = 1'b0;
                                last_next = 1'b1;
                            end
                        end
                        vtp_pkg::ST_ESC:
                        begin
                            if (c == vtp_pkg::CH_LBRK)
                            begin
                                clr        = 1'b1;
                                state_next = vtp_pkg::ST_CSI_ENTRY;
                            end
                            else if (c == vtp_pkg::CH_RBRK)
                            begin
                                olen_next  = '0;
                                pend_next  = 1'b0;
                                sepf_next  = 1'b0;
                                sepi_next  = '0;
                                numok_next = 1'b1;
                                cval_next  = '0;
                                state_next = vtp_pkg::ST_OSC;
                            end
                            else if (c inside {vtp_pkg::CH_DCS, vtp_pkg::CH_SOS,
                                               vtp_pkg::CH_PM, vtp_pkg::CH_APC})
                            begin
                                pend_next  = 1'b0;
                                state_next = vtp_pkg::ST_STR_IGN;
                            end
                            else if (vtp_pkg::is_inter(c))
                            begin
                                inter_next = c[6:0];
                                state_next = vtp_pkg::ST_ESC_INTER;
                            end
                            else
                            begin
                                state_next = vtp_pkg::ST_GROUND;
                                ld        = 1'b1;
                                kind_next = vtp_pkg::KIND_ESC;
                                cv_next   = c;
                                ib_next   = '0;
                                mb_next   = '0;
                                num_next  = '0;
                                om_next   = 1'b0;
                                sub_next  = 1'b0;
                                iv_next   = 1'b0;
                                last_next = 1'b1;
                            end
                        end
                        vtp_pkg::ST_ESC_INTER:
                        begin
                            if (vtp_pkg::is_inter(c))
                            begin
                                inter_next = c[6:0];
                            end
                            else
                            begin
                                state_next = vtp_pkg::ST_GROUND;
                                ld        = 1'b1;
                                kind_next = vtp_pkg::KIND_ESC;
                                cv_next   = c;
                                ib_next   = inter_reg;
                                mb_next   = '0;
                                num_next  = '0;
                                om_next   = 1'b0;
                                sub_next  = 1'b0;
                                iv_next   = 1'b0;
                                last_next = 1'b1;
                            end
                        end
                        vtp_pkg::ST_CSI_ENTRY,
                        vtp_pkg::ST_CSI_PARAM:
                        begin
                            if (vtp_pkg::is_digit(c))
                            begin
                                state_next = vtp_pkg::ST_CSI_PARAM;
                                if (!open_reg)
                                begin
                                    if (cnt_reg < CNT_MAX)
                                    begin
                                        oval_next  = vtp_pkg::mul10_add('0, c);
                                        osub_next  = 1'b0;
                                        oomit_next = 1'b0;
                                        cnt_next   = cnt_reg + CW'(1);
                                        open_next  = 1'b1;
                                    end
                                end
                                else
                                begin
                                    v = oomit_reg ? '0 : oval_reg;
                                    if (v < vtp_pkg::VAL_CLAMP)
                                    begin
                                        v = vtp_pkg::mul10_add(v, c);
                                    end
                                    oval_next  = v;
                                    oomit_next = 1'b0;
                                end
                            end
                            else if (c == vtp_pkg::CH_SEMI || c == vtp_pkg::CH_COLON)
                            begin
                                state_next = vtp_pkg::ST_CSI_PARAM;
                                if (open_reg)
                                begin
                                    pw_en   = 1'b1;
                                    pw_addr = cm1[PAW-1:0];
                                    pw_data = {osub_reg, oomit_reg, oval_reg};
                                end
                                else if (cnt_reg < CNT_MAX)
                                begin
                                    pw_en   = 1'b1;
                                    pw_addr = cnt_reg[PAW-1:0];
                                    pw_data = {1'b0, 1'b1, 20'd0};
                                    cw      = cnt_reg + CW'(1);
                                end
                                open_next = 1'b0;
                                cnt_next  = cw;
                                if (c == vtp_pkg::CH_COLON && cw < CNT_MAX)
                                begin
                                    oval_next  = '0;
                                    oomit_next = 1'b1;
                                    osub_next  = 1'b1;
                                    cnt_next   = cw + CW'(1);
                                    open_next  = 1'b1;
                                end
                            end
                            else if (vtp_pkg::is_marker(c))
                            begin
                                if (s_eff == vtp_pkg::ST_CSI_ENTRY)
                                begin
                                    mark_next  = c[6:0];
                                    state_next = vtp_pkg::ST_CSI_PARAM;
                                end
                                else
                                begin
                                    state_next = vtp_pkg::ST_CSI_IGN;
                                end
                            end
                            else if (vtp_pkg::is_inter(c))
                            begin
                                inter_next = c[6:0];
                                state_next = vtp_pkg::ST_CSI_INTER;
                            end
                            else if (vtp_pkg::is_final(c))
                            begin
                                csi_disp = 1'b1;
                            end
                            else
                            begin
                                state_next = vtp_pkg::ST_CSI_IGN;
                            end
                        end
                        vtp_pkg::ST_CSI_INTER:
                        begin
                            if (vtp_pkg::is_inter(c))
                            begin
                                inter_next = c[6:0];
                            end
                            else if (vtp_pkg::is_final(c))
                            begin
                                csi_disp = 1'b1;
                            end
                            else
                            begin
                                state_next = vtp_pkg::ST_CSI_IGN;
                            end
                        end
                        vtp_pkg::ST_CSI_IGN:
                        begin
                            if (vtp_pkg::is_final(c))
                            begin
                                clr        = 1'b1;
                                state_next = vtp_pkg::ST_GROUND;
                            end
                        end
                        default:
                        begin
                            state_next = vtp_pkg::ST_GROUND;
                        end
                    endcase
                end
            end

            if (csi_disp)
            begin
                state_next = vtp_pkg::ST_GROUND;
                if (cnt_reg == '0)
                begin
                    clr       = 1'b1;
                    ld        = 1'b1;
                    kind_next = vtp_pkg::KIND_CSI;
                    cv_next   = c;
                    ib_next   = inter_reg;
                    mb_next   = mark_reg;
                    num_next  = '0;
                    om_next   = 1'b0;
                    sub_next  = 1'b0;
                    iv_next   = 1'b0;
                    last_next = 1'b1;
                end
                else
                begin
                    // The sequence is cleared when the last parameter leaves.
                    fin_next      = c;
                    seq_next      = vtp_pkg::SQ_READ;
                    mode_osc_next = 1'b0;
                    idx_next      = '0;
                    end_next      = IW'(cnt_reg);
                end
            end
        end

        if (clr)
        begin
            cnt_next   = '0;
            mark_next  = '0;
            inter_next = '0;
            open_next  = 1'b0;
        end

        if (ld)
        begin
            rv_next = 1'b1;
        end
        else
        begin
            rv_next = rv_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vtp_pkg::ST_GROUND;
            pend_reg     <= 1'b0;
            open_reg     <= 1'b0;
            cnt_reg      <= '0;
            mark_reg     <= '0;
            inter_reg    <= '0;
            olen_reg     <= '0;
            seq_reg      <= vtp_pkg::SQ_IDLE;
            mode_osc_reg <= 1'b0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            open_reg     <= open_next;
            cnt_reg      <= cnt_next;
            mark_reg     <= mark_next;
            inter_reg    <= inter_next;
            olen_reg     <= olen_next;
            seq_reg      <= seq_next;
            mode_osc_reg <= mode_osc_next;
            rv_reg       <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oval_reg  <= oval_next;
        osub_reg  <= osub_next;
        oomit_reg <= oomit_next;
        sepf_reg  <= sepf_next;
        sepi_reg  <= sepi_next;
        numok_reg <= numok_next;
        cval_reg  <= cval_next;
        idx_reg   <= idx_next;
        end_reg   <= end_next;
        fin_reg   <= fin_next;
        cmd_reg   <= cmd_next;
        kind_reg  <= kind_next;
        cv_reg    <= cv_next;
        ib_reg    <= ib_next;
        mb_reg    <= mb_next;
        num_reg   <= num_next;
        om_reg    <= om_next;
        sub_reg   <= sub_next;
        iv_reg    <= iv_next;
        last_reg  <= last_next;
    end

    assign res_valid     = rv_reg;
    assign kind          = kind_reg;
    assign char_value    = cv_reg;
    assign inter_byte    = ib_reg;
    assign marker_byte   = mb_reg;
    assign number        = num_reg;
    assign param_omitted = om_reg;
    assign param_sub     = sub_reg;
    assign item_valid    = iv_reg;
    assign last          = last_reg;

`ifndef NO_ASSERTIONS
    // The parameter count never passes the store size.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("parameter count beyond store size");

    // The OSC length never passes the buffer size.
    a_olen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        olen_reg <= OSC_MAX)
        else $error("OSC length beyond buffer size");

    // An open parameter always has a slot counted for it.
    a_open_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (cnt_reg != '0))
        else $error("open parameter without a slot");

    // While a result that is not the last of a run is held, the sequencer
    // is still busy with that run.
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !last) |-> (seq_reg != vtp_pkg::SQ_IDLE))
        else $error("dispatch run ended early");
`endif

endmodule

FILE: rtl/vtp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the parameter store and the OSC buffer; depends on nothing.
module vtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
